### rtl/core/cau_pkg.sv
// Shared constants, mode codes and divider stage payload for the complex arithmetic unit.
package cau_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QW            = 32;
	localparam int DW            = 64;
	localparam int RW            = 96;

	localparam logic [2:0] MODE_ADD  = 3'd0;
	localparam logic [2:0] MODE_SUB  = 3'd1;
	localparam logic [2:0] MODE_MUL  = 3'd2;
	localparam logic [2:0] MODE_DIV  = 3'd3;
	localparam logic [2:0] MODE_SMUL = 3'd4;
	localparam logic [2:0] MODE_SDIV = 3'd5;
	localparam logic [2:0] MODE_ROTI = 3'd6;

	typedef struct packed {
		logic [RW-1:0] rem_re;
		logic [RW-1:0] rem_im;
		logic [DW-1:0] den;
		logic [QW-1:0] quo_re;
		logic [QW-1:0] quo_im;
		logic          neg_re;
		logic          neg_im;
		logic          big_re;
		logic          big_im;
		logic          dz;
		logic          is_div;
		logic [31:0]   dres_re;
		logic [31:0]   dres_im;
		logic          dovf;
	} div_t;

endpackage

### rtl/core/cau_mul.sv
// Product stage: the six signed 32x32 products, registered.
module cau_mul (
	input  logic               clk,
	input  logic signed [31:0] ar,
	input  logic signed [31:0] ai,
	input  logic signed [31:0] br,
	input  logic signed [31:0] bi,
	output logic signed [63:0] rr_s2,
	output logic signed [63:0] ii_s2,
	output logic signed [63:0] rbi_s2,
	output logic signed [63:0] ibr_s2,
	output logic signed [63:0] sqr_s2,
	output logic signed [63:0] sqi_s2
);

	always_ff @(posedge clk) begin
		rr_s2  <= ar * br;
		ii_s2  <= ai * bi;
		rbi_s2 <= ar * bi;
		ibr_s2 <= ai * br;
		sqr_s2 <= br * br;
		sqi_s2 <= bi * bi;
	end

endmodule

### rtl/core/cau_div_stage.sv
// One restoring step of the pipelined divider: resolves quotient bit BIT for both parts.
module cau_div_stage #(
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_i,
	input  cau_pkg::div_t div_i,
	output logic          vld_o,
	output cau_pkg::div_t div_o
);

	localparam int RW = cau_pkg::RW;

	logic [RW-1:0] dsh;
	logic [RW:0]   sub_re;
	logic [RW:0]   sub_im;
	cau_pkg::div_t nxt;

	always_comb begin
		nxt    = div_i;
		dsh    = RW'(div_i.den) << BIT;
		sub_re = {1'b0, div_i.rem_re} - {1'b0, dsh};
		sub_im = {1'b0, div_i.rem_im} - {1'b0, dsh};
		if (!sub_re[RW]) begin
			nxt.rem_re      = sub_re[RW-1:0];
			nxt.quo_re[BIT] = 1'b1;
		end
		if (!sub_im[RW]) begin
			nxt.rem_im      = sub_im[RW-1:0];
			nxt.quo_im[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		div_o <= nxt;
	end

endmodule

### rtl/core/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: operand pipeline, divider chain and result stage.
//
//  channel   handshake          payload
//  request   start / busy       mode, a_re, a_im, b_re, b_im
//  result    done (strobe)      res_re, res_im, div_zero, overflow
//
// Every mode takes the same path: input register, product stage, sum stage,
// magnitude/saturation stage, divider setup, 32 restoring divider stages, result register.
// One request enters every cycle; busy is always low, since nothing stalls the pipe.
// done is high for exactly one cycle per request; the receiver cannot hold it off.
// Reset clears only the valid bits that travel with the data; payload is not reset.
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         mode,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output logic               done,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic               div_zero,
	output logic               overflow
);

	localparam int RW  = cau_pkg::RW;
	localparam int DW  = cau_pkg::DW;
	localparam int QW  = cau_pkg::QW;
	localparam int NST = QW;
	localparam logic signed [65:0] MAXV = 66'sd2147483647;
	localparam logic signed [65:0] MINV = -66'sd2147483648;

	// Request stage
	logic               vld_s1;
	logic [2:0]         mode_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;

	// Product stage
	logic               vld_s2;
	logic [2:0]         mode_s2;
	logic signed [31:0] ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [63:0] rr_s2, ii_s2, rbi_s2, ibr_s2, sqr_s2, sqi_s2;

	// Sum stage
	logic               vld_s3;
	logic signed [65:0] sum_re_s3, sum_im_s3;
	logic [DW-1:0]      den_s3;
	logic               shf_s3, flip_s3, is_div_s3;
	logic signed [65:0] sum_re_c, sum_im_c;
	logic [DW-1:0]      den_c;
	logic               shf_c, flip_c, is_div_c;
	logic signed [32:0] br_x;

	// Magnitude stage
	logic               vld_s4;
	logic [DW-1:0]      nm_re_s4, nm_im_s4, dm_s4;
	logic               neg_re_s4, neg_im_s4, dz_s4, is_div_s4;
	logic [31:0]        dres_re_s4, dres_im_s4;
	logic               dovf_s4;
	logic signed [65:0] mag_re, mag_im, v_re, v_im;
	logic               hi_re, lo_re, hi_im, lo_im;

	// Divider chain
	logic               vld_ch [0:NST];
	cau_pkg::div_t      div_ch [0:NST];
	logic [RW-1:0]      rem_re_c, rem_im_c, den_top;

	// Quotient sign and saturation: {overflow, value}
	function automatic logic [32:0] sat_quo(input logic neg, input logic big,
		input logic [31:0] q);
		logic ov;
		logic [31:0] val;
		if (neg) begin
			ov  = big || (q > 32'h8000_0000);
			val = ov ? 32'h8000_0000 : (32'd0 - q);
		end else begin
			ov  = big || q[31];
			val = ov ? 32'h7FFF_FFFF : q;
		end
		return {ov, val};
	endfunction

	logic [32:0] fq_re, fq_im;

	assign busy = 1'b0;

	// Register the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		ar_s1   <= a_re;
		ai_s1   <= a_im;
		br_s1   <= b_re;
		bi_s1   <= b_im;
		mode_s2 <= mode_s1;
		ar_s2   <= ar_s1;
		ai_s2   <= ai_s1;
		br_s2   <= br_s1;
		bi_s2   <= bi_s1;
	end

	cau_mul u_mul (
		.clk    (clk),
		.ar     (ar_s1),
		.ai     (ai_s1),
		.br     (br_s1),
		.bi     (bi_s1),
		.rr_s2  (rr_s2),
		.ii_s2  (ii_s2),
		.rbi_s2 (rbi_s2),
		.ibr_s2 (ibr_s2),
		.sqr_s2 (sqr_s2),
		.sqi_s2 (sqi_s2)
	);

	// Combine products or operands per mode
	always_comb begin
		sum_re_c = '0;
		sum_im_c = '0;
		den_c    = '0;
		shf_c    = 1'b0;
		flip_c   = 1'b0;
		is_div_c = 1'b0;
		br_x     = 33'(br_s2);
		case (mode_s2)
			cau_pkg::MODE_ADD: begin
				sum_re_c = 66'(ar_s2) + 66'(br_s2);
				sum_im_c = 66'(ai_s2) + 66'(bi_s2);
			end
			cau_pkg::MODE_SUB: begin
				sum_re_c = 66'(ar_s2) - 66'(br_s2);
				sum_im_c = 66'(ai_s2) - 66'(bi_s2);
			end
			cau_pkg::MODE_MUL: begin
				sum_re_c = 66'(rr_s2) - 66'(ii_s2);
				sum_im_c = 66'(rbi_s2) + 66'(ibr_s2);
				shf_c    = 1'b1;
			end
			cau_pkg::MODE_DIV: begin
				sum_re_c = 66'(rr_s2) + 66'(ii_s2);
				sum_im_c = 66'(ibr_s2) - 66'(rbi_s2);
				den_c    = DW'($unsigned(sqr_s2)) + DW'($unsigned(sqi_s2));
				is_div_c = 1'b1;
			end
			cau_pkg::MODE_SMUL: begin
				sum_re_c = 66'(rr_s2);
				sum_im_c = 66'(ibr_s2);
				shf_c    = 1'b1;
			end
			cau_pkg::MODE_SDIV: begin
				sum_re_c = 66'(ar_s2);
				sum_im_c = 66'(ai_s2);
				den_c    = DW'($unsigned(br_x[32] ? -br_x : br_x));
				flip_c   = br_x[32];
				is_div_c = 1'b1;
			end
			cau_pkg::MODE_ROTI: begin
				sum_re_c = -66'(ai_s2);
				sum_im_c = 66'(ar_s2);
			end
			default: begin
				sum_re_c = '0;
				sum_im_c = '0;
			end
		endcase
	end

	// Register the combined sums and the divisor
	always_ff @(posedge clk) begin
		sum_re_s3 <= sum_re_c;
		sum_im_s3 <= sum_im_c;
		den_s3    <= den_c;
		shf_s3    <= shf_c;
		flip_s3   <= flip_c;
		is_div_s3 <= is_div_c;
	end

	// Magnitudes for the divider, floor shift and saturation for the direct modes
	always_comb begin
		mag_re = sum_re_s3[65] ? -sum_re_s3 : sum_re_s3;
		mag_im = sum_im_s3[65] ? -sum_im_s3 : sum_im_s3;
		v_re   = shf_s3 ? (sum_re_s3 >>> FRAC_BITS) : sum_re_s3;
		v_im   = shf_s3 ? (sum_im_s3 >>> FRAC_BITS) : sum_im_s3;
		hi_re  = v_re > MAXV;
		lo_re  = v_re < MINV;
		hi_im  = v_im > MAXV;
		lo_im  = v_im < MINV;
	end

	always_ff @(posedge clk) begin
		nm_re_s4   <= mag_re[DW-1:0];
		nm_im_s4   <= mag_im[DW-1:0];
		dm_s4      <= (den_s3 == '0) ? DW'(1) : den_s3;
		dz_s4      <= is_div_s3 && (den_s3 == '0);
		neg_re_s4  <= sum_re_s3[65] ^ flip_s3;
		neg_im_s4  <= sum_im_s3[65] ^ flip_s3;
		is_div_s4  <= is_div_s3;
		dres_re_s4 <= hi_re ? 32'h7FFF_FFFF : (lo_re ? 32'h8000_0000 : v_re[31:0]);
		dres_im_s4 <= hi_im ? 32'h7FFF_FFFF : (lo_im ? 32'h8000_0000 : v_im[31:0]);
		dovf_s4    <= hi_re || lo_re || hi_im || lo_im;
	end

	// Divider setup: scale numerators, flag quotients of 2^32 or more
	always_comb begin
		rem_re_c = RW'(nm_re_s4) << FRAC_BITS;
		rem_im_c = RW'(nm_im_s4) << FRAC_BITS;
		den_top  = {dm_s4, {(RW-DW){1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ch[0] <= 1'b0;
		end else begin
			vld_ch[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		div_ch[0].rem_re  <= rem_re_c;
		div_ch[0].rem_im  <= rem_im_c;
		div_ch[0].den     <= dm_s4;
		div_ch[0].quo_re  <= '0;
		div_ch[0].quo_im  <= '0;
		div_ch[0].neg_re  <= neg_re_s4;
		div_ch[0].neg_im  <= neg_im_s4;
		div_ch[0].big_re  <= rem_re_c >= den_top;
		div_ch[0].big_im  <= rem_im_c >= den_top;
		div_ch[0].dz      <= dz_s4;
		div_ch[0].is_div  <= is_div_s4;
		div_ch[0].dres_re <= dres_re_s4;
		div_ch[0].dres_im <= dres_im_s4;
		div_ch[0].dovf    <= dovf_s4;
	end

	// Restoring divider, most significant quotient bit first
	for (genvar k = 0; k < NST; k++) begin : g_div
		cau_div_stage #(
			.BIT (NST - 1 - k)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (vld_ch[k]),
			.div_i  (div_ch[k]),
			.vld_o  (vld_ch[k+1]),
			.div_o  (div_ch[k+1])
		);
	end

	// Apply sign and saturate the quotients, pick direct or divider result
	always_comb begin
		fq_re = sat_quo(div_ch[NST].neg_re, div_ch[NST].big_re, div_ch[NST].quo_re);
		fq_im = sat_quo(div_ch[NST].neg_im, div_ch[NST].big_im, div_ch[NST].quo_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_ch[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (!div_ch[NST].is_div) begin
			res_re   <= div_ch[NST].dres_re;
			res_im   <= div_ch[NST].dres_im;
			div_zero <= 1'b0;
			overflow <= div_ch[NST].dovf;
		end else if (div_ch[NST].dz) begin
			res_re   <= '0;
			res_im   <= '0;
			div_zero <= 1'b1;
			overflow <= 1'b0;
		end else begin
			res_re   <= fq_re[31:0];
			res_im   <= fq_im[31:0];
			div_zero <= 1'b0;
			overflow <= fq_re[32] || fq_im[32];
		end
	end

endmodule
